// ----- rtl/core/upd_pkg.sv -----
// Shared types and constants for the URI percent decoder.
// No dependencies; imported by the front, queue, back and top-level modules.
`timescale 1ns / 1ps
`default_nettype none

package upd_pkg;

  localparam int MAX_RESULTS = 4;
  localparam int IDX_W       = $clog2(MAX_RESULTS);
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // One decoded request's worth of result bytes, handed from front to back
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [CNT_W-1:0]            count;      // 1..MAX_RESULTS
    logic                        last;
    logic                        malformed;
  } upd_group_t;

  // Queue status seen by both ends
  typedef struct packed {
    logic full;
    logic valid;
  } upd_qstat_t;

endpackage

`default_nettype wire

// ----- rtl/core/upd_front.sv -----
// Front end: accepts source bytes, tracks escape/UTF-8 sequence state and
// builds result groups. Depends on upd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module upd_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wr_en,
  input  wire logic               cfg_wr_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_byte,
  input  wire logic               in_last,
  input  wire upd_pkg::upd_qstat_t q_stat,
  output logic                    push,
  output upd_pkg::upd_group_t     group
);
  import upd_pkg::*;

  localparam logic [7:0]  PCT_CHAR       = 8'h25;
  localparam logic [31:0] RESV_MAP_PUNCT = 32'hac009858;  // codes 0x20..0x3f
  localparam logic [6:0]  RESV_AT        = 7'h40;

  typedef enum logic [5:0] {
    PH_IDLE    = 6'b000001,
    PH_ESC_HI  = 6'b000010,
    PH_ESC_LO  = 6'b000100,
    PH_SEQ_PCT = 6'b001000,
    PH_SEQ_HI  = 6'b010000,
    PH_SEQ_LO  = 6'b100000
  } phase_t;

  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    return r;
  endfunction

  function automatic logic is_reserved(input logic [6:0] v);
    return (v[6:5] == 2'b01 && RESV_MAP_PUNCT[v[4:0]]) || v == RESV_AT;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

  // strict UTF-8 check of a 2..4 byte sequence
  function automatic logic utf8_ok(input logic [3:0][7:0] sb, input logic [2:0] len);
    logic [7:0] lo;
    logic [7:0] hi;
    logic       ok;
    lo = 8'h80;
    hi = 8'hBF;
    ok = 1'b0;
    case (len)
      3'd2: ok = sb[0] >= 8'hC2 && sb[0] <= 8'hDF && is_cont(sb[1]);
      3'd3: begin
        if (sb[0] == 8'hE0) lo = 8'hA0;
        if (sb[0] == 8'hED) hi = 8'h9F;
        ok = sb[0] >= 8'hE0 && sb[0] <= 8'hEF && sb[1] >= lo && sb[1] <= hi
             && is_cont(sb[2]);
      end
      3'd4: begin
        if (sb[0] == 8'hF0) lo = 8'h90;
        if (sb[0] == 8'hF4) hi = 8'h8F;
        ok = sb[0] >= 8'hF0 && sb[0] <= 8'hF4 && sb[1] >= lo && sb[1] <= hi
             && is_cont(sb[2]) && is_cont(sb[3]);
      end
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  phase_t          phase, phase_next;
  logic [3:0]      high_nibble, high_nibble_next;
  logic [7:0]      esc_hi, esc_hi_next;
  logic [3:0][7:0] seq, seq_next;
  logic [2:0]      seq_len, seq_len_next;
  logic [2:0]      seq_count, seq_count_next;
  logic            skip, skip_next;
  logic            component_mode;

  logic            accept;
  logic            err;
  logic [4:0]      hx;
  logic [7:0]      decoded;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign hx       = hex_decode(in_byte);
  assign decoded  = {high_nibble, hx[3:0]};

  always_comb begin
    phase_next       = phase;
    high_nibble_next = high_nibble;
    esc_hi_next      = esc_hi;
    seq_next         = seq;
    seq_len_next     = seq_len;
    seq_count_next   = seq_count;
    skip_next        = skip;
    err              = 1'b0;
    group            = '0;
    group.last       = in_last;

    if (skip) begin
      if (in_last) begin
        skip_next  = 1'b0;
        phase_next = PH_IDLE;
      end
    end else begin
      case (phase)
        PH_IDLE: begin
          if (in_byte == PCT_CHAR) begin
            phase_next = PH_ESC_HI;
          end else begin
            group.bytes[0] = in_byte;
            group.count    = CNT_W'(1);
          end
        end
        PH_ESC_HI, PH_SEQ_HI: begin
          if (!hx[4]) begin
            err = 1'b1;
          end else begin
            high_nibble_next = hx[3:0];
            esc_hi_next      = in_byte;
            phase_next       = (phase == PH_ESC_HI) ? PH_ESC_LO : PH_SEQ_LO;
          end
        end
        PH_ESC_LO: begin
          if (!hx[4]) begin
            err = 1'b1;
          end else if (!decoded[7]) begin
            phase_next = PH_IDLE;
            if (!component_mode && is_reserved(decoded[6:0])) begin
              // keep the escape as its three source characters
              group.bytes[0] = PCT_CHAR;
              group.bytes[1] = esc_hi;
              group.bytes[2] = in_byte;
              group.count    = CNT_W'(3);
            end else begin
              group.bytes[0] = decoded;
              group.count    = CNT_W'(1);
            end
          end else begin
            // lead byte: length from the run of leading ones
            if (!decoded[5])      seq_len_next = 3'd2;
            else if (!decoded[4]) seq_len_next = 3'd3;
            else if (!decoded[3]) seq_len_next = 3'd4;
            else                  err          = 1'b1;
            seq_next[0]    = decoded;
            seq_count_next = 3'd1;
            phase_next     = PH_SEQ_PCT;
          end
        end
        PH_SEQ_PCT: begin
          if (in_byte != PCT_CHAR) err = 1'b1;
          else                     phase_next = PH_SEQ_HI;
        end
        PH_SEQ_LO: begin
          if (!hx[4]) begin
            err = 1'b1;
          end else begin
            seq_next[seq_count[1:0]] = decoded;
            seq_count_next           = seq_count + 3'd1;
            if (seq_count_next >= seq_len) begin
              phase_next = PH_IDLE;
              if (!utf8_ok(seq_next, seq_len)) begin
                err = 1'b1;
              end else begin
                group.bytes = seq_next;
                group.count = CNT_W'(seq_len);
              end
            end else begin
              phase_next = PH_SEQ_PCT;
            end
          end
        end
        default: err = 1'b1;
      endcase

      // string ends inside an escape or a sequence
      if (!err && in_last && phase_next != PH_IDLE) err = 1'b1;

      if (err) begin
        phase_next      = PH_IDLE;
        skip_next       = !in_last;
        group.bytes     = '0;
        group.count     = CNT_W'(1);
        group.last      = 1'b1;
        group.malformed = 1'b1;
      end
    end
  end

  assign push = accept && (group.count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      high_nibble    <= 4'd0;
      esc_hi         <= 8'd0;
      seq_len        <= 3'd0;
      seq_count      <= 3'd0;
      skip           <= 1'b0;
      component_mode <= 1'b0;
    end else begin
      if (cfg_wr_en) component_mode <= cfg_wr_data;
      if (accept) begin
        phase       <= phase_next;
        high_nibble <= high_nibble_next;
        esc_hi      <= esc_hi_next;
        seq_len     <= seq_len_next;
        seq_count   <= seq_count_next;
        skip        <= skip_next;
      end
    end
  end

  // sequence bytes are payload; only read after being written
  always_ff @(posedge clk) begin
    if (accept) seq <= seq_next;
  end

endmodule

`default_nettype wire

// ----- rtl/core/upd_queue.sv -----
// Short FIFO of result groups between front and back ends.
// Depends on upd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module upd_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire upd_pkg::upd_group_t push_data,
  input  wire logic                pop,
  output upd_pkg::upd_group_t      head,
  output upd_pkg::upd_qstat_t      stat
);
  import upd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int QC_W  = $clog2(DEPTH + 1);

  upd_group_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [QC_W-1:0]  count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign head       = mem[rd_ptr];
  assign stat.full  = (count == QC_W'(DEPTH));
  assign stat.valid = (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop)      count <= count + QC_W'(1);
      else if (pop && !push) count <= count - QC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

`default_nettype wire

// ----- rtl/core/upd_back.sv -----
// Back end: walks the head group into the output register one byte per cycle
// unless out_ready stalls the output. Depends on upd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module upd_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire upd_pkg::upd_group_t head,
  input  wire upd_pkg::upd_qstat_t q_stat,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [7:0]               out_byte,
  output logic                     out_last,
  output logic                     malformed
);
  import upd_pkg::*;

  logic [IDX_W-1:0] idx;
  logic             load;
  logic             grp_end;

  assign load    = q_stat.valid && (!out_valid || out_ready);
  assign grp_end = (CNT_W'(idx) + CNT_W'(1)) == head.count;
  assign pop     = load && grp_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= grp_end ? '0 : idx + IDX_W'(1);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte  <= head.bytes[idx];
      out_last  <= head.last && grp_end;
      malformed <= head.malformed;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/uri_percent_decoder_unit.sv -----
// URI percent decoder: one source byte in and one decoded byte out per cycle when not stalled.
// Path: an accepted byte's group is written into the queue, then loaded into the output register.
// Throughput: 1 input byte/cycle; a 4-byte UTF-8 group followed by plain bytes can
//   fill the QUEUE_DEPTH-group queue and hold input; sink stalls back up.
// Reset (rst, synchronous, active high) clears phase, queue and output valid;
//   component_mode returns to 0 (reserved characters kept escaped).
`timescale 1ns / 1ps
`default_nettype none

module uri_percent_decoder_unit #(
  parameter int QUEUE_DEPTH = 4   // result groups buffered between the two halves
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // configuration: component_mode
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data,
  // source bytes
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  // decoded results
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last,
  output logic            malformed
);
  import upd_pkg::*;

  // Front end turns each accepted request into zero or one group of up to
  // four result bytes (plain byte, re-escaped triple, UTF-8 sequence, or a
  // malformed marker).
  upd_group_t group;
  upd_group_t head;
  upd_qstat_t q_stat;
  logic       q_push;
  logic       q_pop;

  upd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .in_last     (in_last),
    .q_stat      (q_stat),
    .push        (q_push),
    .group       (group)
  );

  // Decouples the two halves so a multi-byte group does not block input
  upd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (group),
    .pop       (q_pop),
    .head      (head),
    .stat      (q_stat)
  );

  // Back end serializes groups into the registered output
  upd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .malformed (malformed)
  );

`ifndef SYNTH
  // a malformed result is always a single zero byte ending the string
  a_malformed_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && malformed |-> out_last && out_byte == 8'd0)
    else $error("malformed result not a zero last byte");

  // front never writes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("queue overflow");

  // back never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_stat.valid)
    else $error("queue underflow");

  // output register is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule

`default_nettype wire
